// ===== sv/s16fd_pkg.sv =====
// ----------------------------------------------------------------------------
// s16fd_pkg
// Shared constants and the command and status types that pass between the
// frame deframer controller and its datapath.
// ----------------------------------------------------------------------------
package s16fd_pkg;

    localparam int FRAME_BYTES = 24;
    localparam int SUM_BYTES   = 22;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);

    localparam logic [7:0] HDR0 = 8'hBB;
    localparam logic [7:0] HDR1 = 8'hAA;

    localparam logic KIND_FRAME    = 1'b0;
    localparam logic KIND_MISMATCH = 1'b1;

    typedef struct packed {
        logic write;
        logic drop1;
        logic drop2;
        logic clear;
        logic sum_clr;
        logic sum_add;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic full;
        logic hdr_ok;
        logic sum_last;
        logic sum_match;
        logic out_free;
    } t_status;

endpackage

// ===== sv/sum16_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// sum16_frame_deframer
// Fixed-length 24-byte frame deframer with a 16-bit additive checksum.
// ----------------------------------------------------------------------------
// Received bytes are taken into a 24-byte window. A byte that does not fill
// the window is taken at once, and such bytes can follow back to back.
// The byte that fills it starts a check: a header check, then the
// accumulator adds one window byte per cycle over the 22 summed bytes, then
// the sum is compared and the result register is loaded. Input ready stays
// low until the check ends, so the next byte is taken only after the result
// is loaded, which waits while a previous result is not yet taken. A bad
// header ends the check after the header state and drops one byte with no
// result; a checksum mismatch drops two bytes and returns an error result;
// a good frame returns its fields and empties the window.
module sum16_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_kind,
    output logic [7:0]  o_device_address,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_encode_flag,
    output logic [7:0]  o_data_length,
    output logic [63:0] o_payload_low,
    output logic [63:0] o_payload_high,
    output logic [15:0] o_received_sum
);
    import s16fd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    s16fd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    s16fd_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_kind           (o_kind),
        .o_device_address (o_device_address),
        .o_command_code   (o_command_code),
        .o_encode_flag    (o_encode_flag),
        .o_data_length    (o_data_length),
        .o_payload_low    (o_payload_low),
        .o_payload_high   (o_payload_high),
        .o_received_sum   (o_received_sum)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_res_valid || i_res_ready))
        else $error("result register loaded while a result is pending");

    a_ready_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_ready |-> !w_status.full)
        else $error("input ready while the window is full");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.write, w_cmd.drop1, w_cmd.drop2 | w_cmd.clear, w_cmd.sum_add}))
        else $error("conflicting window commands");

    a_load_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.sum_add && w_status.sum_last) |=> !o_rx_ready)
        else $error("input accepted before the checked frame was resolved");

endmodule

// ===== sv/s16fd_ctrl.sv =====
// ----------------------------------------------------------------------------
// s16fd_ctrl
// Controller that sequences byte intake, header check, checksum
// accumulation and result hand-off for the frame deframer.
// ----------------------------------------------------------------------------
module s16fd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  s16fd_pkg::t_status i_status,
    output s16fd_pkg::t_cmd    o_cmd
);
    import s16fd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HDR  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_rx_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_rx_valid) begin
                    o_cmd.write = 1'b1;
                    if (i_status.fill_last) begin
                        n_state = ST_HDR;
                    end
                end
            end
            ST_HDR: begin
                if (i_status.hdr_ok) begin
                    o_cmd.sum_clr = 1'b1;
                    n_state       = ST_SUM;
                end else begin
                    o_cmd.drop1 = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_SUM: begin
                o_cmd.sum_add = 1'b1;
                if (i_status.sum_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.clear    = i_status.sum_match;
                    o_cmd.drop2    = !i_status.sum_match;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/s16fd_datapath.sv =====
// ----------------------------------------------------------------------------
// s16fd_datapath
// Byte window, fill count, checksum accumulator and the result register
// of the frame deframer.
// ----------------------------------------------------------------------------
module s16fd_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  s16fd_pkg::t_cmd    i_cmd,
    output s16fd_pkg::t_status o_status,
    input  logic [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_kind,
    output logic [7:0]         o_device_address,
    output logic [7:0]         o_command_code,
    output logic [7:0]         o_encode_flag,
    output logic [7:0]         o_data_length,
    output logic [63:0]        o_payload_low,
    output logic [63:0]        o_payload_high,
    output logic [15:0]        o_received_sum
);
    import s16fd_pkg::*;

    logic [7:0]        r_win [FRAME_BYTES];
    logic [7:0]        n_win [FRAME_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [15:0]       r_sum;
    logic [15:0]       n_sum;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [15:0]       w_got;
    logic [63:0]       w_pay_lo;
    logic [63:0]       w_pay_hi;

    assign w_got = {r_win[SUM_BYTES+1], r_win[SUM_BYTES]};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_pay_lo[8*i +: 8] = r_win[6 + i];
            w_pay_hi[8*i +: 8] = r_win[14 + i];
        end
    end

    assign o_status.fill_last = (r_fill == FILL_W'(FRAME_BYTES - 1));
    assign o_status.full      = (r_fill == FILL_W'(FRAME_BYTES));
    assign o_status.hdr_ok    = (r_win[0] == HDR0) && (r_win[1] == HDR1);
    assign o_status.sum_last  = (r_idx == IDX_W'(SUM_BYTES - 1));
    assign o_status.sum_match = (r_sum == w_got);
    assign o_status.out_free  = !r_out_valid || i_res_ready;

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        n_sum  = r_sum;
        n_idx  = r_idx;
        if (i_cmd.write) begin
            n_win[r_fill[IDX_W-1:0]] = i_rx_byte;
            n_fill = r_fill + FILL_W'(1);
        end
        if (i_cmd.drop1) begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                n_win[i] = r_win[i+1];
            end
            n_fill = r_fill - FILL_W'(1);
        end
        if (i_cmd.drop2) begin
            for (int i = 0; i < FRAME_BYTES - 2; i++) begin
                n_win[i] = r_win[i+2];
            end
            n_fill = r_fill - FILL_W'(2);
        end
        if (i_cmd.clear) begin
            n_fill = '0;
        end
        if (i_cmd.sum_clr) begin
            n_sum = '0;
            n_idx = '0;
        end
        if (i_cmd.sum_add) begin
            n_sum = r_sum + {8'd0, r_win[r_idx]};
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_res_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_received_sum <= w_got;
            if (o_status.sum_match) begin
                o_kind           <= KIND_FRAME;
                o_device_address <= r_win[2];
                o_command_code   <= r_win[3];
                o_encode_flag    <= r_win[4];
                o_data_length    <= r_win[5];
                o_payload_low    <= w_pay_lo;
                o_payload_high   <= w_pay_hi;
            end else begin
                o_kind           <= KIND_MISMATCH;
                o_device_address <= '0;
                o_command_code   <= '0;
                o_encode_flag    <= '0;
                o_data_length    <= '0;
                o_payload_low    <= '0;
                o_payload_high   <= '0;
            end
        end
    end

    assign o_res_valid = r_out_valid;

endmodule
